[src/pcmq_pkg.sv]
`default_nettype none

package pcmq_pkg;

  // Fixed-point position of the incoming sample (1.0 = 2^FractionBits).
  localparam int unsigned FractionBits = 23;

  localparam int unsigned SampleW = 32;
  localparam int unsigned DitherW = 8;
  localparam int unsigned CodeW   = 24;
  localparam int unsigned ValueW  = 25;   // signed clamped value, one bit of headroom
  localparam int unsigned MaxScaleBits = 23;
  localparam int unsigned MagW    = SampleW + MaxScaleBits;
  localparam int unsigned QuotW   = MagW - FractionBits;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegSampleFormat = 8'd0;
  localparam logic [CfgIdxW-1:0] RegDitherOn     = 8'd1;
  localparam logic [CfgIdxW-1:0] RegOffsetBinary = 8'd2;
  localparam logic [CfgIdxW-1:0] RegBigEndianOut = 8'd3;

  // Sample format codes.
  localparam logic [1:0] Fmt8  = 2'd0;
  localparam logic [1:0] Fmt16 = 2'd1;
  localparam logic [1:0] Fmt24 = 2'd2;

  // Dither threshold: dither is subtracted only above this value.
  localparam logic signed [ValueW-1:0] DitherThr8  = -25'sh7f00;
  localparam logic signed [ValueW-1:0] DitherThr16 = -25'sh7fff00;

  localparam logic [CodeW-1:0] SignFlip8  = 24'h80;
  localparam logic [CodeW-1:0] SignFlip16 = 24'h8000;

  typedef enum logic [1:0] {
    SCALE_7,
    SCALE_15,
    SCALE_23
  } scale_e;

  typedef struct packed {
    logic [1:0] sample_format;
    logic       dither_on;
    logic       offset_binary;
    logic       big_endian_out;
  } cfg_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     clip;
  } scale_res_t;

  // Picks the multiplier 2^n - 1 that the current mode needs.
  function automatic scale_e scale_select(input cfg_t cfg);
    scale_e sel;
    sel = SCALE_23;
    if (cfg.sample_format == Fmt8) begin
      sel = cfg.dither_on ? SCALE_15 : SCALE_7;
    end else if (cfg.sample_format == Fmt16) begin
      sel = cfg.dither_on ? SCALE_23 : SCALE_15;
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

[src/pcm_sample_quantizer_top.sv]
// PCM sample quantizer.
// Samples arrive on the slave stream: tdata carries the signed fixed-point
// sample in bits 31:0 and the dither amount in bits 39:32. Each request
// yields exactly one code word on the master stream, with the code in
// tdata bits 23:0 and the saturation flag in tuser bit 0.
// The configuration channel writes one register per request (index 0 is
// the sample format, 1 dither enable, 2 offset binary, 3 byte swap); it is
// always ready and should only be written while no samples are in flight.
// An accepted sample passes through one input register, then the scale,
// clamp, dither and packing logic, then the output register, before its
// code word is valid. Throughput is one sample per clock while the
// receiver does not stall, bounded by that single register-to-register pass.
// At reset both pipeline stages empty and the registers return to 16-bit,
// no dither, two's complement, little-endian.
// When the receiver stalls, the output register holds its word and the
// input register can still take one more sample; only when both are full
// does the slave tready drop.
`default_nettype none

module pcm_sample_quantizer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream. tdata: sample_in [31:0], dither_amt [39:32].
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,
  // Master stream. tdata: code_word [23:0]. tuser: clipped [0].
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,
  output logic [0:0]       m_axis_tuser_o,
  // Configuration write channel.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [pcmq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [pcmq_pkg::CfgDataW-1:0]   cfg_data_i
);

  pcmq_pkg::cfg_t cfg_q, cfg_d;

  logic                                   in_valid_q, in_valid_d;
  logic signed [pcmq_pkg::SampleW-1:0]    in_sample_q, in_sample_d;
  logic [pcmq_pkg::DitherW-1:0]           in_dither_q, in_dither_d;
  logic                                   out_valid_q, out_valid_d;
  logic [pcmq_pkg::CodeW-1:0]             out_code_q, out_code_d;
  logic                                   out_clip_q, out_clip_d;

  logic                 s_accept;
  logic                 out_free;
  pcmq_pkg::scale_res_t scale_res;
  logic [pcmq_pkg::CodeW-1:0] code;
  logic                 clip;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pcmq_pkg::RegSampleFormat: cfg_d.sample_format  = cfg_data_i[1:0];
        pcmq_pkg::RegDitherOn:     cfg_d.dither_on      = cfg_data_i[0];
        pcmq_pkg::RegOffsetBinary: cfg_d.offset_binary  = cfg_data_i[0];
        pcmq_pkg::RegBigEndianOut: cfg_d.big_endian_out = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // The output register frees up when empty or when its word is taken.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    in_sample_d = in_sample_q;
    in_dither_d = in_dither_q;
    if (out_free) in_valid_d = 1'b0;
    if (s_accept) begin
      in_valid_d  = 1'b1;
      in_sample_d = signed'(s_axis_tdata_i[31:0]);
      in_dither_d = s_axis_tdata_i[39:32];
    end
  end

  pcmq_scale u_scale (
    .sample_i    (in_sample_q),
    .scale_sel_i (pcmq_pkg::scale_select(cfg_q)),
    .res_o       (scale_res)
  );

  pcmq_format u_format (
    .cfg_i    (cfg_q),
    .res_i    (scale_res),
    .dither_i (in_dither_q),
    .code_o   (code),
    .clip_o   (clip)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_clip_d  = out_clip_q;
    if (out_free) begin
      out_valid_d = in_valid_q;
      out_code_d  = code;
      out_clip_d  = clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format  <= pcmq_pkg::Fmt16;
      cfg_q.dither_on      <= 1'b0;
      cfg_q.offset_binary  <= 1'b0;
      cfg_q.big_endian_out <= 1'b0;
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_sample_q <= in_sample_d;
    in_dither_q <= in_dither_d;
    out_code_q  <= out_code_d;
    out_clip_q  <= out_clip_d;
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_code_q;
  assign m_axis_tuser_o[0] = out_clip_q;

  // Both stages full and the receiver stalling: no new sample may enter.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while both stages are full");

  // A staged sample moves into a free output register on the next edge.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_free |=> m_axis_tvalid_o)
    else $error("staged sample was lost");

  // An empty pipeline always takes a new sample.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q && !out_valid_q |-> s_axis_tready_o)
    else $error("empty pipeline refuses input");

endmodule

`default_nettype wire

[src/pcmq_scale.sv]
`default_nettype none

module pcmq_scale (
  input  wire logic signed [pcmq_pkg::SampleW-1:0] sample_i,
  input  wire pcmq_pkg::scale_e                    scale_sel_i,
  output pcmq_pkg::scale_res_t                     res_o
);

  localparam int unsigned MagW   = pcmq_pkg::MagW;
  localparam int unsigned ValueW = pcmq_pkg::ValueW;
  localparam int unsigned FB     = pcmq_pkg::FractionBits;

  logic                              neg;
  logic [pcmq_pkg::SampleW-1:0]      ms;
  logic [MagW-1:0]                   ms_w;
  logic [MagW-1:0]                   shifted;
  logic [MagW-1:0]                   mag;
  logic [MagW-1:0]                   hi;
  logic [MagW-1:0]                   lim;
  logic [pcmq_pkg::QuotW-1:0]        quot;
  logic signed [ValueW-1:0]          qv;
  logic signed [ValueW-1:0]          hi_v;

  always_comb begin
    neg  = sample_i[pcmq_pkg::SampleW-1];
    ms   = neg ? (pcmq_pkg::SampleW'(0) - unsigned'(sample_i)) : unsigned'(sample_i);
    ms_w = MagW'(ms);
    // Multiply by 2^n - 1 as a shift and one subtract.
    unique case (scale_sel_i)
      pcmq_pkg::SCALE_7: begin
        shifted = ms_w << 7;
        hi      = MagW'(24'h7f);
      end
      pcmq_pkg::SCALE_15: begin
        shifted = ms_w << 15;
        hi      = MagW'(24'h7fff);
      end
      default: begin
        shifted = ms_w << 23;
        hi      = MagW'(24'h7fffff);
      end
    endcase
    mag  = shifted - ms_w;
    // The negative limit is one step larger in magnitude.
    lim  = neg ? ((hi + MagW'(1)) << FB) : (hi << FB);
    quot = mag[MagW-1:FB];
    qv   = signed'({1'b0, quot[ValueW-2:0]});
    hi_v = signed'(hi[ValueW-1:0]);
    res_o.clip = mag > lim;
    if (res_o.clip) begin
      res_o.value = neg ? (-hi_v - ValueW'(1)) : hi_v;
    end else begin
      res_o.value = neg ? -qv : qv;
    end
  end

endmodule

`default_nettype wire

[src/pcmq_format.sv]
`default_nettype none

module pcmq_format (
  input  wire pcmq_pkg::cfg_t                      cfg_i,
  input  wire pcmq_pkg::scale_res_t                res_i,
  input  wire logic [pcmq_pkg::DitherW-1:0]        dither_i,
  output logic [pcmq_pkg::CodeW-1:0]               code_o,
  output logic                                     clip_o
);

  localparam int unsigned ValueW = pcmq_pkg::ValueW;

  logic                     dither_en;
  logic signed [ValueW-1:0] thr;
  logic signed [ValueW-1:0] vd;
  logic signed [ValueW-1:0] vt;
  logic signed [ValueW-1:0] w;
  logic [pcmq_pkg::CodeW-1:0] raw;

  always_comb begin
    dither_en = cfg_i.dither_on &&
                (cfg_i.sample_format == pcmq_pkg::Fmt8 ||
                 cfg_i.sample_format == pcmq_pkg::Fmt16);
    thr = (cfg_i.sample_format == pcmq_pkg::Fmt8) ? pcmq_pkg::DitherThr8
                                                  : pcmq_pkg::DitherThr16;
    vd = res_i.value;
    if (res_i.value > thr) begin
      vd = res_i.value - signed'({{(ValueW - pcmq_pkg::DitherW){1'b0}}, dither_i});
    end
    // Divide by 256 toward zero: bias negative values before the shift.
    vt = (vd + (vd[ValueW-1] ? ValueW'(255) : ValueW'(0))) >>> 8;
    w  = dither_en ? vt : res_i.value;
    raw = w[pcmq_pkg::CodeW-1:0];

    code_o = '0;
    clip_o = res_i.clip;
    unique case (cfg_i.sample_format)
      pcmq_pkg::Fmt8: begin
        code_o = {16'h0, raw[7:0]};
        if (cfg_i.offset_binary) code_o = code_o ^ pcmq_pkg::SignFlip8;
      end
      pcmq_pkg::Fmt16: begin
        code_o = {8'h0, raw[15:0]};
        if (cfg_i.offset_binary) code_o = code_o ^ pcmq_pkg::SignFlip16;
        if (cfg_i.big_endian_out) code_o = {8'h0, code_o[7:0], code_o[15:8]};
      end
      pcmq_pkg::Fmt24: begin
        code_o = raw;
        if (cfg_i.big_endian_out) code_o = {raw[7:0], raw[15:8], raw[23:16]};
      end
      default: begin
        code_o = '0;
        clip_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
